### rtl/xbc_pkg.sv
// Package for the XOR/base64 codec: shared types, constants and the
// base64 alphabet functions. No dependencies.
`default_nettype none

package xbc_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int MAX_RESULTS   = 4;

    localparam logic [63:0] KEY_BYTES_RESET  = 64'd7955819;
    localparam logic [3:0]  KEY_LENGTH_RESET = 4'd3;
    localparam logic        DIRECTION_RESET  = 1'b0;

    localparam logic [1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [1:0] CFG_KEY_BYTES  = 2'd1;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd2;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic        dir;
        logic [63:0] key;
        logic [3:0]  klen;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } t_result;

    typedef struct packed {
        logic [2:0]                    count;
        t_result [MAX_RESULTS-1:0]     item;
    } t_batch;

    // Six-bit value to base64 character.
    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx};
        if (idx < 6'd26)      return 8'h41 + v;
        else if (idx < 6'd52) return 8'h61 + v - 8'd26;
        else if (idx < 6'd62) return 8'h30 + v - 8'd52;
        else if (idx == 6'd62) return 8'h2B;
        else                  return 8'h2F;
    endfunction

    // Character to {valid, six-bit value}.
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            d = c - 8'h41;
            return {1'b1, d[5:0]};
        end else if (c inside {[8'h61:8'h7A]}) begin
            d = c - 8'h61 + 8'd26;
            return {1'b1, d[5:0]};
        end else if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30 + 8'd52;
            return {1'b1, d[5:0]};
        end else if (c == 8'h2B) begin
            return {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

endpackage

`default_nettype wire

### rtl/xbc_in_if.sv
// Input channel of the codec: valid/ready handshake with one byte and a
// last flag. No dependencies.
`default_nettype none

interface xbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

### rtl/xbc_out_if.sv
// Result channel of the codec: valid/ready handshake with the result byte,
// its valid flag and a last flag. No dependencies.
`default_nettype none

interface xbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    output ready);
endinterface

`default_nettype wire

### rtl/xbc_engine.sv
// Stream state of the codec and the logic that turns one item into a batch
// of up to four results. Depends on xbc_pkg.
`default_nettype none

module xbc_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire xbc_pkg::t_cfg i_cfg,
    input  wire logic          i_clear,
    input  wire logic          i_process,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output xbc_pkg::t_batch    o_batch
);
    import xbc_pkg::*;

    logic [13:0] r_acc,  n_acc;
    logic [3:0]  r_held, n_held;
    logic [2:0]  r_kpos, n_kpos;
    logic [1:0]  r_cm4,  n_cm4;
    logic        r_pad,  n_pad;

    always_comb begin
        logic [3:0]  len;
        logic [3:0]  pos_inc;
        logic [7:0]  kb;
        logic [2:0]  kpos_adv;
        logic [13:0] acc;
        logic [3:0]  h;
        logic [2:0]  n;
        logic [1:0]  cm;
        logic [5:0]  idx;
        logic [6:0]  dv;
        logic [7:0]  v;
        t_batch      b;

        // Key byte at the current position and the position after it.
        len = i_cfg.klen;
        if (len == 4'd0)                 len = 4'd1;
        if (len > 4'(MAX_KEY_BYTES))     len = 4'(MAX_KEY_BYTES);
        kb       = i_cfg.key[8*r_kpos +: 8];
        pos_inc  = {1'b0, r_kpos} + 4'd1;
        kpos_adv = (pos_inc >= len) ? 3'd0 : pos_inc[2:0];

        b      = '0;
        n      = 3'd0;
        cm     = r_cm4;
        acc    = r_acc;
        h      = r_held;
        n_kpos = r_kpos;
        n_pad  = r_pad;
        idx    = 6'd0;
        dv     = 7'd0;
        v      = 8'd0;

        if (i_cfg.dir == DIR_ENCODE) begin
            acc    = {r_acc[5:0], i_byte ^ kb};
            h      = r_held + 4'd8;
            n_kpos = kpos_adv;
            for (int i = 0; i < 2; i++) begin
                if (h >= 4'd6) begin
                    idx = 6'(acc >> (h - 4'd6));
                    if (n < 3'(MAX_RESULTS)) begin
                        b.item[n[1:0]] = '{out_byte: b64_char(idx), has_byte: 1'b1,
                                           out_last: 1'b0};
                        n = n + 3'd1;
                    end
                    cm = cm + 2'd1;
                    h  = h - 4'd6;
                end
            end
            if (i_last) begin
                // Leftover bits go out as one character, zero-filled on the right.
                if (h != 4'd0) begin
                    idx = 6'(acc << (4'd6 - h));
                    if (n < 3'(MAX_RESULTS)) begin
                        b.item[n[1:0]] = '{out_byte: b64_char(idx), has_byte: 1'b1,
                                           out_last: 1'b0};
                        n = n + 3'd1;
                    end
                    cm = cm + 2'd1;
                end
                for (int i = 0; i < MAX_RESULTS; i++) begin
                    if (cm != 2'd0 && n < 3'(MAX_RESULTS)) begin
                        b.item[n[1:0]] = '{out_byte: PAD_CHAR, has_byte: 1'b1,
                                           out_last: 1'b0};
                        n  = n + 3'd1;
                        cm = cm + 2'd1;
                    end
                end
            end
        end else if (!r_pad) begin
            if (i_byte == PAD_CHAR) begin
                n_pad = 1'b1;
            end else begin
                dv = b64_value(i_byte);
                if (dv[6]) begin
                    acc = {r_acc[7:0], dv[5:0]};
                    h   = r_held + 4'd6;
                    if (h >= 4'd8) begin
                        v = 8'(acc >> (h - 4'd8));
                        b.item[0] = '{out_byte: v ^ kb, has_byte: 1'b1, out_last: 1'b0};
                        n      = 3'd1;
                        n_kpos = kpos_adv;
                        h      = h - 4'd8;
                    end
                end
            end
        end

        n_acc  = acc;
        n_held = h;
        n_cm4  = cm;

        if (i_last) begin
            // An item that closes the stream with nothing to say still marks the end.
            if (n == 3'd0) begin
                b.item[0] = '{out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b0};
                n = 3'd1;
            end
            b.item[2'(n - 3'd1)].out_last = 1'b1;
            n_acc  = '0;
            n_held = '0;
            n_kpos = '0;
            n_cm4  = '0;
            n_pad  = 1'b0;
        end

        b.count = n;
        o_batch = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc  <= '0;
            r_held <= '0;
            r_kpos <= '0;
            r_cm4  <= '0;
            r_pad  <= 1'b0;
        end else if (i_process) begin
            r_acc  <= n_acc;
            r_held <= n_held;
            r_kpos <= n_kpos;
            r_cm4  <= n_cm4;
            r_pad  <= n_pad;
        end
    end

endmodule

`default_nettype wire

### rtl/xbc_outq.sv
// Result register of the codec: holds one batch of up to four results and
// hands them out one transfer per cycle while ready. Depends on xbc_pkg and xbc_out_if.
`default_nettype none

module xbc_outq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire xbc_pkg::t_batch i_batch,
    output logic                 o_free,
    xbc_out_if.source            o_out
);
    import xbc_pkg::*;

    t_result [MAX_RESULTS-1:0] r_item;
    logic [2:0]                r_cnt;
    logic [1:0]                r_rd;
    logic                      w_fire;

    assign o_out.valid    = (r_cnt != 3'd0);
    assign o_out.out_byte = r_item[r_rd].out_byte;
    assign o_out.has_byte = r_item[r_rd].has_byte;
    assign o_out.out_last = r_item[r_rd].out_last;

    assign w_fire = o_out.valid && o_out.ready;
    // Room for a new batch when empty, or as the last held result leaves in this cycle.
    assign o_free = (r_cnt == 3'd0) || (r_cnt == 3'd1 && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.count;
            r_rd  <= '0;
        end else if (w_fire) begin
            r_cnt <= r_cnt - 3'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_batch.item;
        end
    end

endmodule

`default_nettype wire

### rtl/xor_base64_codec.sv
// Top level of the streaming XOR/base64 codec; depends on xbc_pkg, the channel
// interfaces, xbc_engine and xbc_outq.
// Items pass through the input register and then the result register. An item holds the
// result register until all its results have transferred (at most one per byte in decode,
// one or two per byte in encode, up to four for the closing byte); the next item moves in
// as the last of them leaves. Reset is synchronous, active low, and clears all control state.
`default_nettype none

module xor_base64_codec (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    xbc_in_if.sink           i_in,
    xbc_out_if.source        o_out
);
    import xbc_pkg::*;

    // Configuration registers. Writing the direction also restarts the
    // stream, so any partially packed bits are dropped.
    logic        r_dir;
    logic [63:0] r_key;
    logic [3:0]  r_klen;
    t_cfg        w_cfg;
    logic        w_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIRECTION_RESET;
            r_key  <= KEY_BYTES_RESET;
            r_klen <= KEY_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTION:  r_dir  <= i_cfg_data[0];
                CFG_KEY_BYTES:  r_key  <= i_cfg_data;
                CFG_KEY_LENGTH: r_klen <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign w_cfg   = '{dir: r_dir, key: r_key, klen: r_klen};
    assign w_clear = i_cfg_we && (i_cfg_idx == CFG_DIRECTION);

    // Input register. It takes a new transfer whenever it is empty or its
    // current item moves into the result register in the same cycle, so one
    // item can wait here while results wait on the output.
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       w_free;
    logic       w_process;
    logic       w_take;
    t_batch     w_batch;

    assign w_process  = r_in_vld && w_free;
    assign i_in.ready = !r_in_vld || w_process;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_process) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    // Single pass: the engine turns the held item into a whole batch of results,
    // and the result register drains it one transfer per cycle while o_out is ready.
    xbc_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_clear   (w_clear),
        .i_process (w_process),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_batch   (w_batch)
    );

    xbc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_process),
        .i_batch (w_batch),
        .o_free  (w_free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
